/* design/lcsc_pkg.sv */
// Shared codes for the lock-light command scroll converter.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package lcsc_pkg;

    // Item kinds carried in the input tuser field
    localparam logic [1:0] OP_MOTION = 2'd0;
    localparam logic [1:0] OP_LIGHTS = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW_TICKS = 2'd0;
    localparam logic [1:0] REG_H_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_V_THRESHOLD  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] WINDOW_TICKS_RESET = 8'd25;
    localparam logic [6:0] H_THRESHOLD_RESET  = 7'd60;
    localparam logic [6:0] V_THRESHOLD_RESET  = 7'd15;

    // Commands decoded when a window closes
    localparam logic [1:0] CMD_NONE    = 2'b00;
    localparam logic [1:0] CMD_SCROLL  = 2'b01;
    localparam logic [1:0] CMD_DPI     = 2'b10;
    localparam logic [1:0] CMD_RESTART = 2'b11;

    // Wheel step codes, two-bit signed
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_PLUS = 2'b01;
    localparam logic [1:0] STEP_MINUS = 2'b11;

    // Field positions in the result tdata
    localparam int OUT_PX_LSB    = 0;
    localparam int OUT_PY_LSB    = 8;
    localparam int OUT_WH_LSB    = 16;
    localparam int OUT_WV_LSB    = 18;
    localparam int OUT_MODE_BIT  = 20;
    localparam int OUT_DPI_BIT   = 21;
    localparam int OUT_RESET_BIT = 22;

endpackage

`default_nettype wire

/* design/led_command_scroll_converter_top.sv */
// Top level of the lock-light command scroll converter.
// Depends on lcsc_pkg for item kinds, command codes and register indexes.
`default_nettype none

// Converts pointer motion into wheel steps while scroll mode is on, and
// decodes commands that the host signals by toggling the num and caps lock
// lights inside a timed window. Every accepted item yields exactly one
// result item. The state update and the result are computed from the input
// item and the state in a single step and land in one output register, so a
// new item is accepted in every cycle as long as the output register is
// empty or being taken (s_axis_tready is low only while a result waits and
// m_axis_tready is low). The result is registered and is valid in the cycle
// after its item is accepted. Configuration writes take effect at the next
// edge and must be made while no item is in flight. Operation code 3 is
// ignored and gives a result with only scroll_mode set to the current mode.
// After reset both previous lock lights are taken as off.
module led_command_scroll_converter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // motion_x[7:0], motion_y[15:8],
                                            // num_light[16], caps_light[17], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // pointer_x[7:0], pointer_y[15:8],
                                            // wheel_h[17:16], wheel_v[19:18],
                                            // scroll_mode[20], dpi_cycle_pulse[21],
                                            // reset_pulse[22], zero pad
);
    import lcsc_pkg::*;

    // Configuration
    logic [7:0] window_ticks_reg;
    logic [6:0] h_threshold_reg;
    logic [6:0] v_threshold_reg;

    // Converter state
    logic       scroll_on_reg,     scroll_on_next;
    logic       prev_num_reg,      prev_num_next;
    logic       prev_caps_reg,     prev_caps_next;
    logic       window_open_reg,   window_open_next;
    logic [7:0] window_left_reg,   window_left_next;
    logic       num_odd_reg,       num_odd_next;
    logic       caps_odd_reg,      caps_odd_next;
    logic [1:0] command_reg,       command_next;
    logic [7:0] accum_x_reg,       accum_x_next;
    logic [7:0] accum_y_reg,       accum_y_next;

    // Output register
    logic        out_valid_reg;
    logic [23:0] out_data_reg, out_data_next;

    // Input fields
    logic [7:0] motion_x;
    logic [7:0] motion_y;
    logic       num_light;
    logic       caps_light;

    // Datapath intermediates
    logic [7:0]        sum_x, sum_y;
    logic signed [8:0] sum_x_wide, sum_y_wide;
    logic signed [8:0] thr_h_wide, thr_v_wide;
    logic              x_pos, x_neg, y_pos, y_neg;
    logic              num_change, caps_change;
    logic [7:0]        px, py;
    logic [1:0]        wheel_h, wheel_v;
    logic              dpi_pulse, reset_pulse;
    logic              accept;

    assign motion_x   = s_axis_tdata[7:0];
    assign motion_y   = s_axis_tdata[15:8];
    assign num_light  = s_axis_tdata[16];
    assign caps_light = s_axis_tdata[17];

    // Accept while the output register is empty or drains in this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Wrapping 8-bit accumulation and signed threshold compares
    assign sum_x      = accum_x_reg + motion_x;
    assign sum_y      = accum_y_reg + motion_y;
    assign sum_x_wide = $signed({sum_x[7], sum_x});
    assign sum_y_wide = $signed({sum_y[7], sum_y});
    assign thr_h_wide = $signed({2'b00, h_threshold_reg});
    assign thr_v_wide = $signed({2'b00, v_threshold_reg});
    assign x_pos      = sum_x_wide > thr_h_wide;
    assign x_neg      = sum_x_wide < -thr_h_wide;
    assign y_pos      = sum_y_wide > thr_v_wide;
    assign y_neg      = sum_y_wide < -thr_v_wide;

    assign num_change  = num_light ^ prev_num_reg;
    assign caps_change = caps_light ^ prev_caps_reg;

    always_comb
    begin
        scroll_on_next   = scroll_on_reg;
        prev_num_next    = prev_num_reg;
        prev_caps_next   = prev_caps_reg;
        window_open_next = window_open_reg;
        window_left_next = window_left_reg;
        num_odd_next     = num_odd_reg;
        caps_odd_next    = caps_odd_reg;
        command_next     = command_reg;
        accum_x_next     = accum_x_reg;
        accum_y_next     = accum_y_reg;
        px               = 8'd0;
        py               = 8'd0;
        wheel_h          = STEP_ZERO;
        wheel_v          = STEP_ZERO;
        dpi_pulse        = 1'b0;
        reset_pulse      = 1'b0;

        case (s_axis_tuser)
            OP_MOTION:
            begin
                if (scroll_on_reg)
                begin
                    // Step and clear an axis on a crossing, else keep the sum
                    accum_x_next = (x_pos || x_neg) ? 8'd0 : sum_x;
                    accum_y_next = (y_pos || y_neg) ? 8'd0 : sum_y;
                    // Horizontal steps are inverted relative to motion
                    if (x_pos)
                        wheel_h = STEP_MINUS;
                    else if (x_neg)
                        wheel_h = STEP_PLUS;
                    if (y_pos)
                        wheel_v = STEP_PLUS;
                    else if (y_neg)
                        wheel_v = STEP_MINUS;
                end
                else
                begin
                    px = motion_x;
                    py = motion_y;
                end
            end
            OP_LIGHTS:
            begin
                // Open a window on the first light update
                if (!window_open_reg)
                begin
                    window_open_next = 1'b1;
                    window_left_next = window_ticks_reg;
                end
                // Every second toggle of a light sets its command bit
                if (num_change)
                    num_odd_next = !num_odd_reg;
                if (caps_change)
                    caps_odd_next = !caps_odd_reg;
                command_next = command_reg |
                               {caps_change && caps_odd_reg, num_change && num_odd_reg};
                prev_num_next  = num_light;
                prev_caps_next = caps_light;
            end
            OP_TICK:
            begin
                if (window_open_reg)
                begin
                    if (window_left_reg <= 8'd1)
                    begin
                        // Window closes: decode and clear
                        unique case (command_reg)
                            CMD_NONE:    ;
                            CMD_SCROLL:  scroll_on_next = !scroll_on_reg;
                            CMD_DPI:     dpi_pulse = 1'b1;
                            CMD_RESTART: reset_pulse = 1'b1;
                            default:     ;
                        endcase
                        command_next     = CMD_NONE;
                        num_odd_next     = 1'b0;
                        caps_odd_next    = 1'b0;
                        window_open_next = 1'b0;
                        window_left_next = 8'd0;
                    end
                    else
                    begin
                        window_left_next = window_left_reg - 8'd1;
                    end
                end
            end
            default:
            begin
                // Unused kind: state holds, result carries only the mode
            end
        endcase

        out_data_next                = 24'd0;
        out_data_next[OUT_PX_LSB +: 8] = px;
        out_data_next[OUT_PY_LSB +: 8] = py;
        out_data_next[OUT_WH_LSB +: 2] = wheel_h;
        out_data_next[OUT_WV_LSB +: 2] = wheel_v;
        out_data_next[OUT_MODE_BIT]    = scroll_on_next;
        out_data_next[OUT_DPI_BIT]     = dpi_pulse;
        out_data_next[OUT_RESET_BIT]   = reset_pulse;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_TICKS_RESET;
            h_threshold_reg  <= H_THRESHOLD_RESET;
            v_threshold_reg  <= V_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_TICKS: window_ticks_reg <= cfg_data;
                REG_H_THRESHOLD:  h_threshold_reg  <= cfg_data[6:0];
                REG_V_THRESHOLD:  v_threshold_reg  <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    // State advances only on an accepted item; output valid sets on one and clears when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_on_reg   <= 1'b0;
            prev_num_reg    <= 1'b0;
            prev_caps_reg   <= 1'b0;
            window_open_reg <= 1'b0;
            window_left_reg <= 8'd0;
            num_odd_reg     <= 1'b0;
            caps_odd_reg    <= 1'b0;
            command_reg     <= CMD_NONE;
            accum_x_reg     <= 8'd0;
            accum_y_reg     <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                scroll_on_reg   <= scroll_on_next;
                prev_num_reg    <= prev_num_next;
                prev_caps_reg   <= prev_caps_next;
                window_open_reg <= window_open_next;
                window_left_reg <= window_left_next;
                num_odd_reg     <= num_odd_next;
                caps_odd_reg    <= caps_odd_next;
                command_reg     <= command_next;
                accum_x_reg     <= accum_x_next;
                accum_y_reg     <= accum_y_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

/* design/lcsc_checker.sv */
// Port-level assertions for the lock-light command scroll converter.
// Depends on lcsc_pkg; bound to led_command_scroll_converter_top below.
`default_nettype none

module lcsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    import lcsc_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The input side is never blocked while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // A non-motion item gives zero pointer and wheel fields
    a_non_motion_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_MOTION)
        |=> m_axis_tvalid && (m_axis_tdata[19:0] == 20'd0))
        else $error("non-motion item gave motion or wheel output");

    // Only a closing window pulses, so the pulses exclude motion and each other
    a_pulse_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[OUT_DPI_BIT] || m_axis_tdata[OUT_RESET_BIT])
        |-> !(m_axis_tdata[OUT_DPI_BIT] && m_axis_tdata[OUT_RESET_BIT])
            && (m_axis_tdata[19:0] == 20'd0))
        else $error("pulse combined with another output");

    // Pointer passthrough and wheel steps never appear in the same result
    a_wheel_xor_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[19:16] != 4'd0) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("wheel step with pointer motion");

endmodule

bind led_command_scroll_converter_top lcsc_checker u_lcsc_checker (.*);

`default_nettype wire
